// ----- hdl/rdf_pkg.sv -----
// Shared constants for the radix digit formatter.
`default_nettype none
package rdf_pkg;

    localparam int DEF_MAX_RADIX  = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int ALPHA_N   = 16;  // alphabet slots across both registers
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;   // one digit index, 0..15
    localparam int RADIX_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'd43;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [DIGIT_W-1:0] t_digit;

endpackage
`default_nettype wire

// ----- hdl/radix_digit_formatter.sv -----
// Signed integer to text in a configurable radix, digit-serial divider.
// Per item: an accept step, a check of all 16 alphabet slots, a sign step, then
// the bit-serial divider for each digit (one quotient bit a cycle), then a read
// and an emit step per digit out of the digit stack, the emit waiting for output room.
// One item at a time: a new value is accepted only while idle.
// Synchronous active-low reset clears the configuration registers, the sequencer and the output beat.
`default_nettype none
module radix_digit_formatter #(
    parameter int MAX_RADIX  = rdf_pkg::DEF_MAX_RADIX,
    parameter int VALUE_BITS = rdf_pkg::DEF_VALUE_BITS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration write channel
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [rdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [rdf_pkg::CFG_W-1:0]      i_cfg_data,
    // input channel
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  signed [31:0]             i_value,
    // result channel
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [rdf_pkg::CHAR_W-1:0]     o_out_char,
    output logic                           o_char_valid,
    output logic                           o_base_error,
    output logic                           o_last
);

    localparam int IDX_W = $clog2(VALUE_BITS);      // digit stack index, bit counter
    localparam int CNT_W = $clog2(VALUE_BITS + 1);  // digit count, 0..VALUE_BITS
    localparam int DW    = rdf_pkg::DIGIT_W;
    localparam int RW    = rdf_pkg::RADIX_W;

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_ERR   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // configuration registers
    logic [RW-1:0]                  r_radix;
    logic [rdf_pkg::CFG_W-1:0]      r_alpha_lo;
    logic [rdf_pkg::CFG_W-1:0]      r_alpha_hi;

    // sequencer and datapath
    logic [2:0]                     r_state;
    logic                           r_neg;
    logic                           r_err;
    logic [DW-1:0]                  r_chk_idx;
    logic [VALUE_BITS-1:0]          r_mag;
    logic [DW-1:0]                  r_rem;
    logic [IDX_W-1:0]               r_bit;
    logic [CNT_W-1:0]               r_count;
    rdf_pkg::t_digit                r_rd_digit;
    rdf_pkg::t_digit                r_store [VALUE_BITS];

    // output beat register
    logic                           r_out_valid;
    rdf_pkg::t_char                 r_out_char;
    logic                           r_char_valid;
    logic                           r_base_error;
    logic                           r_last;

    // combinational helpers
    logic [2*rdf_pkg::CFG_W-1:0]    w_alpha_all;
    rdf_pkg::t_char                 w_alpha [rdf_pkg::ALPHA_N];
    rdf_pkg::t_char                 w_cur;
    logic                           w_bad;
    logic                           w_slot;
    logic                           w_load;
    logic                           w_accept;
    logic [VALUE_BITS-1:0]          w_raw;
    logic [DW:0]                    n_trial;
    logic                           n_qbit;
    logic [DW-1:0]                  n_rem;
    logic [VALUE_BITS-1:0]          n_mag;
    logic [CNT_W-1:0]               n_rd_cnt;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_char_valid;
    assign o_base_error = r_base_error;
    assign o_last       = r_last;

    assign w_accept = i_in_valid && o_in_ready;
    // room for a new beat: register empty or being drained this cycle
    assign w_slot   = !r_out_valid || i_out_ready;
    // a new beat enters the output register this cycle
    assign w_load   = w_slot && ((r_state == S_SIGN && r_neg) || r_state == S_ERR ||
                                 r_state == S_EMIT);
    assign w_raw    = i_value[VALUE_BITS-1:0];

    // alphabet bytes, digit 0 in the low byte of the low register
    assign w_alpha_all = {r_alpha_hi, r_alpha_lo};
    always_comb begin
        for (int i = 0; i < rdf_pkg::ALPHA_N; i++) begin
            w_alpha[i] = w_alpha_all[8*i +: 8];
        end
    end

    // one alphabet slot per cycle against sign characters and all later slots below the radix
    always_comb begin
        w_cur = w_alpha[r_chk_idx];
        w_bad = 1'b0;
        if ({1'b0, r_chk_idx} < r_radix) begin
            if (w_cur == rdf_pkg::MINUS_CHAR || w_cur == rdf_pkg::PLUS_CHAR) begin
                w_bad = 1'b1;
            end
            for (int b = 0; b < rdf_pkg::ALPHA_N; b++) begin
                if (RW'(b) > {1'b0, r_chk_idx} && RW'(b) < r_radix && w_alpha[b] == w_cur) begin
                    w_bad = 1'b1;
                end
            end
        end
    end

    // restoring division step: shift in the next magnitude bit, subtract radix if it fits
    always_comb begin
        n_trial  = {r_rem, r_mag[VALUE_BITS-1]};
        n_qbit   = (n_trial >= r_radix);
        n_rem    = n_qbit ? DW'(n_trial - r_radix) : n_trial[DW-1:0];
        n_mag    = {r_mag[VALUE_BITS-2:0], n_qbit};
        n_rd_cnt = r_count - CNT_W'(1);
    end

    // digit stack, pushed least significant first and popped in reverse
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && r_bit == IDX_W'(VALUE_BITS - 1)) begin
            r_store[r_count[IDX_W-1:0]] <= n_rem;
        end
        if (r_state == S_READ) begin
            r_rd_digit <= r_store[n_rd_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= '0;
            r_alpha_lo  <= '0;
            r_alpha_hi  <= '0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_mag       <= '0;
        end else begin
            // register writes; an index beyond the list is dropped
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rdf_pkg::REG_RADIX:      r_radix    <= i_cfg_data[RW-1:0];
                    rdf_pkg::REG_ALPHA_LOW:  r_alpha_lo <= i_cfg_data;
                    rdf_pkg::REG_ALPHA_HIGH: r_alpha_hi <= i_cfg_data;
                    default: ;
                endcase
            end

            // drain the output beat unless a new one is loaded below
            if (r_out_valid && i_out_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        // take the magnitude; the most negative value fits unsigned
                        r_neg     <= w_raw[VALUE_BITS-1];
                        r_mag     <= w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
                        r_err     <= (r_radix < RW'(2)) || (r_radix > RW'(MAX_RADIX));
                        r_chk_idx <= '0;
                        r_rem     <= '0;
                        r_bit     <= '0;
                        r_count   <= '0;
                        r_state   <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_err     <= r_err | w_bad;
                    r_chk_idx <= r_chk_idx + DW'(1);
                    if (r_chk_idx == DW'(rdf_pkg::ALPHA_N - 1)) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    // the minus goes out even with a bad alphabet
                    if (!r_neg || w_slot) begin
                        if (r_neg) begin
                            r_out_valid  <= 1'b1;
                            r_out_char   <= rdf_pkg::MINUS_CHAR;
                            r_char_valid <= 1'b1;
                            r_base_error <= 1'b0;
                            r_last       <= 1'b0;
                        end
                        r_state <= r_err ? S_ERR : S_DIV;
                    end
                end
                S_ERR: begin
                    if (w_slot) begin
                        r_out_valid  <= 1'b1;
                        r_out_char   <= '0;
                        r_char_valid <= 1'b0;
                        r_base_error <= 1'b1;
                        r_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_mag <= n_mag;
                    if (r_bit == IDX_W'(VALUE_BITS - 1)) begin
                        // digit complete: push it, stop once the quotient is zero
                        r_count <= r_count + CNT_W'(1);
                        r_rem   <= '0;
                        r_bit   <= '0;
                        if (n_mag == '0) begin
                            r_state <= S_READ;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_bit <= r_bit + IDX_W'(1);
                    end
                end
                S_READ: begin
                    r_count <= n_rd_cnt;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_out_valid  <= 1'b1;
                        r_out_char   <= w_alpha[r_rd_digit];
                        r_char_valid <= 1'b1;
                        r_base_error <= 1'b0;
                        r_last       <= (r_count == '0);
                        r_state      <= (r_count == '0) ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- dv/digit_stream_checker.sv -----
`timescale 1ns / 100ps
// Beat checker for radix_digit_formatter: predicts the character stream and compares it.
module digit_stream_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    input  wire                           i_cfg_ready,
    input  wire  [rdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [rdf_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                           i_in_valid,
    input  wire                           i_in_ready,
    input  wire  [31:0]                   i_value,
    input  wire                           i_out_valid,
    input  wire                           i_out_ready,
    input  wire  [rdf_pkg::CHAR_W-1:0]    i_out_char,
    input  wire                           i_char_valid,
    input  wire                           i_base_error,
    input  wire                           i_last,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [rdf_pkg::CHAR_W-1:0] ch;
        logic                       char_valid;
        logic                       base_error;
        logic                       last;
    } t_char_beat;

    t_char_beat                  expected_beats [$];
    t_char_beat                  got_beat;
    t_char_beat                  want_beat;
    logic [rdf_pkg::RADIX_W-1:0] radix_q;
    logic [rdf_pkg::CFG_W-1:0]   alpha_lo_q;
    logic [rdf_pkg::CFG_W-1:0]   alpha_hi_q;
    int                          fails;

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
        radix_q      = '0;
        alpha_lo_q   = '0;
        alpha_hi_q   = '0;
    end

    function automatic logic [rdf_pkg::CHAR_W-1:0] glyph(
        input logic [rdf_pkg::DIGIT_W-1:0] idx);
        if (idx[3])
            return alpha_hi_q[{idx[2:0], 3'b000} +: rdf_pkg::CHAR_W];
        return alpha_lo_q[{idx[2:0], 3'b000} +: rdf_pkg::CHAR_W];
    endfunction

    function automatic bit alphabet_sound();
        int a;
        int b;
        if (radix_q < 2 || radix_q > rdf_pkg::DEF_MAX_RADIX)
            return 1'b0;
        for (a = 0; a < radix_q; a++) begin
            if (glyph(a[3:0]) == rdf_pkg::MINUS_CHAR || glyph(a[3:0]) == rdf_pkg::PLUS_CHAR)
                return 1'b0;
            for (b = a + 1; b < radix_q; b++)
                if (glyph(a[3:0]) == glyph(b[3:0]))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queue the beats of one value: optional minus, then digits high first or the error beat.
    task automatic predict_beats(input logic [31:0] v);
        logic [31:0]                 mag;
        logic [31:0]                 rem;
        logic [rdf_pkg::DIGIT_W-1:0] digits [32];
        int                          n;
        int                          k;
        mag = v;
        if (v[31]) begin
            expected_beats.push_back({rdf_pkg::MINUS_CHAR, 1'b1, 1'b0, 1'b0});
            mag = -v;
        end
        if (!alphabet_sound()) begin
            expected_beats.push_back({8'h00, 1'b0, 1'b1, 1'b1});
            return;
        end
        n = 0;
        do begin
            rem       = mag % radix_q;
            digits[n] = rem[rdf_pkg::DIGIT_W-1:0];
            n++;
            mag = mag / radix_q;
        end while (mag != 0);
        for (k = n - 1; k >= 0; k--)
            expected_beats.push_back({glyph(digits[k]), 1'b1, 1'b0, (k == 0)});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_q    = '0;
            alpha_lo_q = '0;
            alpha_hi_q = '0;
            expected_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rdf_pkg::REG_RADIX:      radix_q    = i_cfg_data[rdf_pkg::RADIX_W-1:0];
                    rdf_pkg::REG_ALPHA_LOW:  alpha_lo_q = i_cfg_data;
                    rdf_pkg::REG_ALPHA_HIGH: alpha_hi_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_beats(i_value);
            if (i_out_valid && i_out_ready) begin
                got_beat = {i_out_char, i_char_valid, i_base_error, i_last};
                if (expected_beats.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected beat char %02h valid %0b err %0b last %0b",
                                 $time, got_beat.ch, got_beat.char_valid,
                                 got_beat.base_error, got_beat.last);
                    fails++;
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (got_beat.ch !== want_beat.ch ||
                        got_beat.char_valid !== want_beat.char_valid ||
                        got_beat.base_error !== want_beat.base_error ||
                        got_beat.last !== want_beat.last) begin
                        if (fails < 10) begin
                            $write("%0t: beat mismatch, expected char %02h valid %0b",
                                   $time, want_beat.ch, want_beat.char_valid);
                            $write(" err %0b last %0b,", want_beat.base_error,
                                   want_beat.last);
                            $display(" got char %02h valid %0b err %0b last %0b",
                                     got_beat.ch, got_beat.char_valid,
                                     got_beat.base_error, got_beat.last);
                        end
                        fails++;
                    end
                end
            end
        end
        o_fail_count = fails;
        o_pending    = expected_beats.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for radix_digit_formatter: directed then random values under changing alphabets.
module tb;

    // Slowest legal item is radix 2 on the most negative value, 33 beats through
    // receiver stalls; the limit takes the whole run several times over.
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 1200;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 30;

    // unmapped index, must be ignored
    localparam logic [rdf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // "01234567" and "89abcdef", digit 0 in the low byte
    localparam logic [rdf_pkg::CFG_W-1:0] HEX_LO  = 64'h3736_3534_3332_3130;
    localparam logic [rdf_pkg::CFG_W-1:0] HEX_HI  = 64'h6665_6463_6261_3938;
    // decimal alphabet whose digit 0 is the zero byte
    localparam logic [rdf_pkg::CFG_W-1:0] NUL_LO  = 64'h3736_3534_3332_3100;
    localparam logic [rdf_pkg::CFG_W-1:0] NUL_HI  = 64'h0000_0000_0000_3938;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [rdf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rdf_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic [31:0]                   i_value     = '0;
    logic                          i_out_ready = 1'b0;

    wire                           o_cfg_ready;
    wire                           o_in_ready;
    wire                           o_out_valid;
    wire [rdf_pkg::CHAR_W-1:0]     o_out_char;
    wire                           o_char_valid;
    wire                           o_base_error;
    wire                           o_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int tx_idle_pct = 31;
    int rx_idle_pct = 69;
    bit hold_go     = 1'b0;

    radix_digit_formatter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_base_error (o_base_error),
        .o_last       (o_last)
    );

    digit_stream_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_char   (o_out_char),
        .i_char_valid (o_char_valid),
        .i_base_error (o_base_error),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bound the run: a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: stall at random, and once hold off for a long stretch so that the
    // block backs up and the sender is left waiting with a beat on offer.
    initial begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_used) begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one value and hold it until the beat is taken; return at the falling edge
    // after acceptance with valid still high, so back-to-back beats need no dip.
    task automatic send_value(input logic [31:0] v);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid = 1'b1;
        i_value    = v;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rdf_pkg::CFG_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Drop the input offer and wait until every predicted beat has come back.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Load a new alphabet while idle; junk in the upper radix bits must be masked off.
    task automatic apply_setting(input logic [rdf_pkg::RADIX_W-1:0] r,
                                 input logic [rdf_pkg::CFG_W-1:0] lo,
                                 input logic [rdf_pkg::CFG_W-1:0] hi);
        wait_drained();
        write_reg(rdf_pkg::REG_RADIX, {27'($urandom), 32'($urandom), r});
        write_reg(rdf_pkg::REG_ALPHA_LOW, lo);
        write_reg(rdf_pkg::REG_ALPHA_HIGH, hi);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly sound alphabets of distinct bytes; a quarter broken by radix, repeat or sign.
    task automatic pick_setting(output logic [rdf_pkg::RADIX_W-1:0] r,
                                output logic [rdf_pkg::CFG_W-1:0] lo,
                                output logic [rdf_pkg::CFG_W-1:0] hi);
        logic [rdf_pkg::CHAR_W-1:0] slot [16];
        int                         a;
        int                         b;
        int                         span;
        int                         kind;
        int                         pick;
        bit                         clash;
        pick = $urandom_range(16, 2);
        r    = pick[rdf_pkg::RADIX_W-1:0];
        span = pick;
        for (a = 0; a < 16; a++) begin
            do begin
                pick    = $urandom_range(255);
                slot[a] = pick[rdf_pkg::CHAR_W-1:0];
                clash = (a < span) &&
                        (slot[a] == rdf_pkg::MINUS_CHAR || slot[a] == rdf_pkg::PLUS_CHAR);
                for (b = 0; b < a; b++)
                    if (a < span && slot[b] == slot[a])
                        clash = 1'b1;
            end while (clash);
        end
        kind = $urandom_range(99);
        if (kind < 25) begin
            case (kind % 3)
                0: begin
                    // radix 0, 1 or above the maximum
                    b    = $urandom_range(16);
                    pick = (b < 2) ? b : b + 15;
                    r    = pick[rdf_pkg::RADIX_W-1:0];
                end
                1: begin
                    a = $urandom_range(span - 1, 1);
                    b = $urandom_range(a - 1, 0);
                    slot[a] = slot[b];
                end
                default: begin
                    slot[$urandom_range(span - 1)] = $urandom_range(1) ?
                                                     rdf_pkg::MINUS_CHAR : rdf_pkg::PLUS_CHAR;
                end
            endcase
        end
        for (a = 0; a < 8; a++) begin
            lo[a*8 +: 8] = slot[a];
            hi[a*8 +: 8] = slot[a+8];
        end
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int          kind;
        kind = $urandom_range(9);
        if (kind == 0)
            v = 32'h8000_0000;
        else if (kind == 1)
            v = 32'h7fff_ffff;
        else if (kind < 5)
            v = $urandom;
        else begin
            // spread magnitudes so that short and long digit strings both show up
            v = $urandom >> $urandom_range(31);
            if ($urandom_range(1))
                v = -v;
        end
        return v;
    endfunction

    initial begin : stimulus
        logic [rdf_pkg::RADIX_W-1:0] r;
        logic [rdf_pkg::CFG_W-1:0]   lo;
        logic [rdf_pkg::CFG_W-1:0]   hi;
        int                          seg;
        int                          n;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset alphabet has radix 0: only the minus and the error beat come out.
        send_value(32'd0);
        send_value(-7);

        // Hex: zero, unit values and both ends of the range.
        apply_setting(5'd16, HEX_LO, HEX_HI);
        send_value(32'd0);
        send_value(32'd1);
        send_value(-1);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        send_value(32'd255);
        send_value(-256);

        // Binary: the longest digit strings.
        apply_setting(5'd2, HEX_LO, HEX_HI);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(32'd5);

        // Radix above the maximum, at the top of the field, and radix one.
        apply_setting(5'd17, HEX_LO, HEX_HI);
        send_value(-5);
        apply_setting(5'd31, HEX_LO, HEX_HI);
        send_value(32'd3);
        apply_setting(5'd1, HEX_LO, HEX_HI);
        send_value(-1);

        // Repeated character, plus sign and minus sign inside the alphabet.
        apply_setting(5'd3, 64'h0000_0000_0062_6161, 64'h0);
        send_value(-2);
        apply_setting(5'd4, 64'h0000_0000_2b63_6261, 64'h0);
        send_value(32'd9);
        apply_setting(5'd4, 64'h0000_0000_6463_622d, 64'h0);
        send_value(-9);

        // Zero byte used as an ordinary digit.
        apply_setting(5'd10, NUL_LO, NUL_HI);
        send_value(32'd0);
        send_value(32'd100);
        send_value(32'h8000_0000);

        // A write to the unmapped index must leave the alphabet alone.
        wait_drained();
        write_reg(REG_SPARE, '1);
        i_cfg_valid = 1'b0;
        send_value(32'd10);

        // Random part: fresh alphabet per segment, idling regime per third of the run.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            pick_setting(r, lo, hi);
            apply_setting(r, lo, hi);
            if (seg < SEGMENTS / 3) begin
                tx_idle_pct = 31;
                rx_idle_pct = 69;
            end else if (seg < 2 * SEGMENTS / 3) begin
                tx_idle_pct = 69;
                rx_idle_pct = 31;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Start the long receiver hold with the sender running flat out.
            if (seg == 2 * SEGMENTS / 3)
                hold_go = 1'b1;
            for (n = 0; n < SEG_ITEMS; n++)
                send_value(pick_value());
        end

        wait_drained();
        // Hold on for about one worst-case item to catch any stray beats.
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- radix_digit_formatter.f -----
hdl/rdf_pkg.sv
hdl/radix_digit_formatter.sv
dv/digit_stream_checker.sv
dv/tb.sv
